>>> hdl/assert_macros.svh
// Assertion macros used by the top level of the pixel unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> hdl/wnp_pkg.sv
// Types, constants and helper functions of the Worley noise pixel unit.
package wnp_pkg;

   localparam int MAX_FEATURE_LIMIT_DEF = 10;
   localparam int COORD_BITS_DEF        = 16;

   localparam int SEED_W     = 32;
   localparam int SIZE_W     = 16;
   localparam int COUNT_W    = 17;
   localparam int COORD_W    = 16;
   localparam int DIST_W     = 17;
   localparam int FEAT_W     = 19;
   localparam int SQ_W       = 37;
   localparam int ROOT_STEPS = 19;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int DIV_W       = 32;
   localparam int DIV_STEP_W  = $clog2(DIV_W);

   localparam logic [SEED_W-1:0] LCG_MUL   = 32'd1103515245;
   localparam logic [SEED_W-1:0] LCG_ADD   = 32'd12345;
   localparam logic [SEED_W-1:0] FNV_BASIS = 32'd2166136261;
   localparam logic [SEED_W-1:0] FNV_PRIME = 32'd16777619;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BASE_SEED    = 3'd0,
      CSR_CELL_SIDE    = 3'd1,
      CSR_CELLS_ACROSS = 3'd2,
      CSR_CELLS_DOWN   = 3'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DIVX,
      ST_DIVY,
      ST_CHECK,
      ST_SEED,
      ST_CELL,
      ST_HASH2,
      ST_LCG0,
      ST_MOD,
      ST_CNT,
      ST_FX_LCG,
      ST_FX_DIV,
      ST_FY_LCG,
      ST_FY_DIV,
      ST_SCAN_INIT,
      ST_SCAN,
      ST_DRAIN,
      ST_SQRT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [SIZE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DIV_W-1:0]  quotient;
      logic [SIZE_W-1:0] remainder;
   } div_rsp_type;

   function automatic logic [SEED_W-1:0] lcg_next(input logic [SEED_W-1:0] s);
      return LCG_MUL * s + LCG_ADD;
   endfunction

   function automatic logic [SEED_W-1:0] fnv_mix(input logic [SEED_W-1:0] s,
                                                 input logic [SEED_W-1:0] v);
      return ((FNV_BASIS ^ s) * FNV_PRIME) ^ v;
   endfunction

endpackage

>>> hdl/wnp_divider.sv
// Restoring divider, one quotient bit per cycle, shared by the pixel unit.
module wnp_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  wnp_pkg::div_req_type div_req,
   output wnp_pkg::div_rsp_type div_rsp
);
   import wnp_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [DIV_W-1:0]      quot_ff, quot_in;
   logic [SIZE_W-1:0]     rem_ff, rem_in;
   logic [SIZE_W-1:0]     divisor_ff, divisor_in;
   logic [SIZE_W:0]       trial;
   logic [SIZE_W:0]       diff;
   logic                  fits;

   always_comb begin
      trial      = {rem_ff, quot_ff[DIV_W-1]};
      diff       = trial - {1'b0, divisor_ff};
      fits       = trial >= {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         quot_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DIV_W-2:0], fits};
         rem_in  = fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_STEP_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff    <= step_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quot_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

>>> hdl/worley_noise_pixel_unit.sv
// Top level of the Worley F1 noise pixel unit.
// Each request word carries one pixel coordinate and each response word carries the
// floor of the distance from that pixel to the nearest feature point in its cell and
// the eight neighbours, capped at floor(1.5 * cell side). One pixel is handled at a
// time. Two passes of the shared serial divider find the cell; if it is cached, the
// feature memory is then read one entry per cycle, for each stored feature of the
// nine cells (at most 9 * (MAX_FEATURE_LIMIT - 1)), the distance pipeline drains
// and a 19-step integer square root finishes the word. When the pixel lands in
// another cell than the cached one, or none is cached, the nine cells are rebuilt
// first: the seed once, then each cell and each of its features; the same divider
// reduces every random feature offset modulo the cell side. The feature count of a
// cell is reduced by a reciprocal multiplication, registered in ST_MOD and used in
// ST_CNT. Any write to one of the four registers forces a rebuild on the next
// pixel. The next request word is taken while a finished response word still waits
// for the consumer.
`include "assert_macros.svh"

module worley_noise_pixel_unit #(
   parameter int MAX_FEATURE_LIMIT = wnp_pkg::MAX_FEATURE_LIMIT_DEF,
   parameter int COORD_BITS        = wnp_pkg::COORD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [wnp_pkg::COORD_W-1:0]      req_pixel_x,
   input  logic [wnp_pkg::COORD_W-1:0]      req_pixel_y,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [wnp_pkg::DIST_W-1:0]       rsp_distance,
   input  logic                             csr_write_enable,
   input  logic [wnp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [wnp_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import wnp_pkg::*;

   // Features per cell, the feature memory and the widths that follow from them.
   localparam int PER_CELL = MAX_FEATURE_LIMIT - 1;
   localparam int DEPTH    = 9 * PER_CELL;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int N_W      = $clog2(PER_CELL + 1);
   localparam int MASK_BITS = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
   localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((64'd1 << MASK_BITS) - 64'd1);
   localparam logic [SQ_W-1:0] ROOT_BIT0 = SQ_W'(1) << (SQ_W - 1);

   // Reciprocal of the feature count modulus: the high word of seed * MOD_MAGIC,
   // corrected by half the difference and shifted, is the exact 32-bit quotient.
   localparam int MOD_L   = $clog2(PER_CELL);
   localparam int MOD_SH1 = (MOD_L > 0) ? 1 : 0;
   localparam int MOD_SH2 = (MOD_L > 1) ? MOD_L - 1 : 0;
   localparam logic [63:0] MOD_MAGIC64 =
      ((((64'd1 << MOD_L) - 64'(PER_CELL)) << 32) / 64'(PER_CELL)) + 64'd1;
   localparam logic [SEED_W-1:0] MOD_MAGIC = MOD_MAGIC64[SEED_W-1:0];

   // Configuration registers.
   logic [SEED_W-1:0]  base_seed_ff;
   logic [SIZE_W-1:0]  cell_side_ff;
   logic [COUNT_W-1:0] cells_across_ff;
   logic [COUNT_W-1:0] cells_down_ff;
   logic               csr_hit;

   // Control.
   state_type state_ff, state_in;
   logic      cache_valid_ff;
   logic [COORD_W-1:0] cached_col_ff, cached_row_ff;

   // Pixel and cell.
   logic [COORD_W-1:0] px_ff, py_ff, ccol_ff, crow_ff;

   // Rebuild datapath.
   logic [SEED_W-1:0]   h0_ff, s_ff, wrow_ff, mod_t1_ff;
   logic [FEAT_W-1:0]   colbase_ff, rowbase_ff, fc_ff;
   logic [3:0]          k_ff;
   logic [1:0]          dx_ff, dy_ff;
   logic [N_W-1:0]      j_ff, n_ff;
   logic [N_W-1:0]      count_ff [9];
   logic [COUNT_W:0]    col_s, row_s;
   logic signed [34:0]  colbase_p, rowbase_p;
   logic [SEED_W-1:0]   wcol, wrow, s_lcg;
   logic [63:0]         mod_prod;
   logic [SEED_W-1:0]   mod_q, mod_r;
   logic [N_W-1:0]      n_new, n_cur;
   logic                last_cell;

   // Feature memory: one word per feature, column and row side by side.
   logic [2*FEAT_W-1:0] feature_mem [DEPTH];
   logic [2*FEAT_W-1:0] mem_q_ff;
   logic [2*FEAT_W-1:0] mem_wdata;
   logic [ADDR_W-1:0]   mem_addr;
   logic                mem_we;

   // Distance pipeline.
   logic                rd_pend_ff, sq_valid_ff;
   logic [35:0]         sqx_ff, sqy_ff;
   logic [SQ_W-1:0]     minsq_ff, sq_sum;
   logic signed [19:0]  ddx, ddy;
   logic signed [39:0]  sqx_full, sqy_full;

   // Square root.
   logic [SQ_W-1:0]     sv_ff, root_ff, bit_ff, root_trial;
   logic [4:0]          sq_step_ff;
   logic                root_fits;

   // Result.
   logic                rsp_valid_ff;
   logic [DIST_W-1:0]   rsp_distance_ff;
   logic [SIZE_W-1:0]   cs_eff;
   logic [DIST_W-1:0]   cap;
   logic [DIST_W-1:0]   dist_final;
   logic                req_take, rsp_take, out_load;

   div_req_type div_req;
   div_rsp_type div_rsp;

   wnp_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // A wrapped cell index: beyond the edge wraps to zero, minus one to the last cell.
   function automatic logic [SEED_W-1:0] wrap_idx(input logic [COUNT_W:0] c,
                                                  input logic [COUNT_W-1:0] cnt);
      logic [SEED_W-1:0] w;
      if (c[COUNT_W]) begin
         w = {{(SEED_W-COUNT_W){1'b0}}, cnt} - SEED_W'(1);
      end else if (c[COUNT_W-1:0] >= cnt) begin
         w = '0;
      end else begin
         w = {{(SEED_W-COUNT_W){1'b0}}, c[COUNT_W-1:0]};
      end
      return w;
   endfunction

   assign cs_eff    = (cell_side_ff == '0) ? SIZE_W'(1) : cell_side_ff;
   assign cap       = {1'b0, cs_eff} + {2'b00, cs_eff[SIZE_W-1:1]};
   assign csr_hit   = csr_write_enable && (csr_index == CSR_BASE_SEED ||
                      csr_index == CSR_CELL_SIDE || csr_index == CSR_CELLS_ACROSS ||
                      csr_index == CSR_CELLS_DOWN);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // Neighbour cell of the current rebuild step and its origin in pixels.
   always_comb begin
      col_s     = {2'b00, ccol_ff} + {{(COUNT_W-1){1'b0}}, dx_ff} - (COUNT_W+1)'(1);
      row_s     = {2'b00, crow_ff} + {{(COUNT_W-1){1'b0}}, dy_ff} - (COUNT_W+1)'(1);
      colbase_p = 35'($signed(col_s)) * 35'($signed({1'b0, cs_eff}));
      rowbase_p = 35'($signed(row_s)) * 35'($signed({1'b0, cs_eff}));
      wcol      = wrap_idx(col_s, cells_across_ff);
      wrow      = wrap_idx(row_s, cells_down_ff);
      s_lcg     = lcg_next(s_ff);
      mod_prod  = {32'd0, s_ff} * {32'd0, MOD_MAGIC};
      mod_q     = (mod_t1_ff + ((s_ff - mod_t1_ff) >> MOD_SH1)) >> MOD_SH2;
      mod_r     = s_ff - mod_q * SEED_W'(PER_CELL);
      n_new     = mod_r[N_W-1:0] + N_W'(1);
      n_cur     = count_ff[k_ff];
      last_cell = (k_ff == 4'd8);
   end

   // Distance stages and the square-root step.
   always_comb begin
      ddx        = $signed({4'b0000, px_ff}) - $signed({mem_q_ff[2*FEAT_W-1],
                                                        mem_q_ff[2*FEAT_W-1:FEAT_W]});
      ddy        = $signed({4'b0000, py_ff}) - $signed({mem_q_ff[FEAT_W-1],
                                                        mem_q_ff[FEAT_W-1:0]});
      sqx_full   = 40'(ddx) * 40'(ddx);
      sqy_full   = 40'(ddy) * 40'(ddy);
      sq_sum     = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      root_trial = root_ff + bit_ff;
      root_fits  = sv_ff >= root_trial;
      dist_final = (root_ff < SQ_W'(cap)) ? root_ff[DIST_W-1:0] : cap;
   end

   // Memory port: written during a rebuild, read during the scan.
   always_comb begin
      mem_we    = (state_ff == ST_FY_DIV) && div_rsp.done;
      mem_wdata = {fc_ff, rowbase_ff + {{(FEAT_W-SIZE_W){1'b0}}, div_rsp.remainder}};
      mem_addr  = ADDR_W'(32'(k_ff) * PER_CELL + 32'(j_ff));
   end

   // Next state and divider requests.
   always_comb begin
      state_in         = state_ff;
      div_req.start    = 1'b0;
      div_req.dividend = s_lcg;
      div_req.divisor  = cs_eff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               div_req.start    = 1'b1;
               div_req.dividend = {{(DIV_W-COORD_W){1'b0}}, req_pixel_x & COORD_MASK};
               state_in         = ST_DIVX;
            end
         end
         ST_DIVX: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = {{(DIV_W-COORD_W){1'b0}}, py_ff};
               state_in         = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (div_rsp.done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (cache_valid_ff && ccol_ff == cached_col_ff && crow_ff == cached_row_ff) begin
               state_in = ST_SCAN_INIT;
            end else begin
               state_in = ST_SEED;
            end
         end
         ST_SEED:  state_in = ST_CELL;
         ST_CELL:  state_in = ST_HASH2;
         ST_HASH2: state_in = ST_LCG0;
         ST_LCG0:  state_in = ST_MOD;
         ST_MOD:   state_in = ST_CNT;
         ST_CNT:   state_in = ST_FX_LCG;
         ST_FX_LCG: begin
            div_req.start = 1'b1;
            state_in      = ST_FX_DIV;
         end
         ST_FX_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_FY_LCG;
            end
         end
         ST_FY_LCG: begin
            div_req.start = 1'b1;
            state_in      = ST_FY_DIV;
         end
         ST_FY_DIV: begin
            if (div_rsp.done) begin
               if (j_ff != n_ff - N_W'(1)) begin
                  state_in = ST_FX_LCG;
               end else if (last_cell) begin
                  state_in = ST_SCAN_INIT;
               end else begin
                  state_in = ST_CELL;
               end
            end
         end
         ST_SCAN_INIT: state_in = ST_SCAN;
         ST_SCAN: begin
            if (j_ff == n_cur - N_W'(1) && last_cell) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_pend_ff && !sq_valid_ff) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_step_ff == 5'(ROOT_STEPS - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers and the cell cache tag.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_seed_ff    <= '0;
         cell_side_ff    <= SIZE_W'(256);
         cells_across_ff <= COUNT_W'(1);
         cells_down_ff   <= COUNT_W'(1);
         cache_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BASE_SEED:    base_seed_ff    <= csr_write_data;
               CSR_CELL_SIDE:    cell_side_ff    <= csr_write_data[SIZE_W-1:0];
               CSR_CELLS_ACROSS: cells_across_ff <= csr_write_data[COUNT_W-1:0];
               CSR_CELLS_DOWN:   cells_down_ff   <= csr_write_data[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (csr_hit) begin
            cache_valid_ff <= 1'b0;
         end else if (state_ff == ST_CHECK) begin
            cache_valid_ff <= 1'b1;
         end
      end
   end

   // Datapath registers, steered by the state.
   always_ff @(posedge clock) begin
      if (req_take) begin
         px_ff <= req_pixel_x & COORD_MASK;
         py_ff <= req_pixel_y & COORD_MASK;
      end
      if (state_ff == ST_DIVX && div_rsp.done) begin
         ccol_ff <= div_rsp.quotient[COORD_W-1:0];
      end
      if (state_ff == ST_DIVY && div_rsp.done) begin
         crow_ff <= div_rsp.quotient[COORD_W-1:0];
      end
      case (state_ff)
         ST_CHECK: begin
            cached_col_ff <= ccol_ff;
            cached_row_ff <= crow_ff;
            k_ff  <= '0;
            dx_ff <= '0;
            dy_ff <= '0;
         end
         ST_SEED: h0_ff <= (FNV_BASIS ^ base_seed_ff) * FNV_PRIME;
         ST_CELL: begin
            colbase_ff <= colbase_p[FEAT_W-1:0];
            rowbase_ff <= rowbase_p[FEAT_W-1:0];
            wrow_ff    <= wrow;
            s_ff       <= h0_ff ^ wcol;
         end
         ST_HASH2: s_ff <= fnv_mix(s_ff, wrow_ff);
         ST_LCG0, ST_FX_LCG, ST_FY_LCG: s_ff <= s_lcg;
         ST_MOD: mod_t1_ff <= mod_prod[63:32];
         ST_CNT: begin
            count_ff[k_ff] <= n_new;
            n_ff           <= n_new;
            j_ff           <= '0;
         end
         ST_FX_DIV: begin
            if (div_rsp.done) begin
               fc_ff <= colbase_ff + {{(FEAT_W-SIZE_W){1'b0}}, div_rsp.remainder};
            end
         end
         ST_FY_DIV: begin
            if (div_rsp.done) begin
               if (j_ff != n_ff - N_W'(1)) begin
                  j_ff <= j_ff + N_W'(1);
               end else begin
                  k_ff <= k_ff + 4'd1;
                  if (dx_ff == 2'd2) begin
                     dx_ff <= '0;
                     dy_ff <= dy_ff + 2'd1;
                  end else begin
                     dx_ff <= dx_ff + 2'd1;
                  end
               end
            end
         end
         ST_SCAN_INIT: begin
            k_ff     <= '0;
            j_ff     <= '0;
            minsq_ff <= '1;
         end
         ST_SCAN: begin
            if (j_ff == n_cur - N_W'(1)) begin
               j_ff <= '0;
               k_ff <= k_ff + 4'd1;
            end else begin
               j_ff <= j_ff + N_W'(1);
            end
         end
         ST_DRAIN: begin
            sv_ff      <= minsq_ff;
            root_ff    <= '0;
            bit_ff     <= ROOT_BIT0;
            sq_step_ff <= '0;
         end
         ST_SQRT: begin
            if (root_fits) begin
               sv_ff   <= sv_ff - root_trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff     <= bit_ff >> 2;
            sq_step_ff <= sq_step_ff + 5'd1;
         end
         default: ;
      endcase
      // Compare stage of the scan pipeline.
      if (sq_valid_ff && sq_sum < minsq_ff) begin
         minsq_ff <= sq_sum;
      end
      sqx_ff <= sqx_full[35:0];
      sqy_ff <= sqy_full[35:0];
      if (out_load) begin
         rsp_distance_ff <= dist_final;
      end
   end

   // Feature memory with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         feature_mem[mem_addr] <= mem_wdata;
      end
      mem_q_ff <= feature_mem[mem_addr];
   end

   // Valid flags of the scan pipeline and of the response word.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         sq_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff  <= (state_ff == ST_SCAN);
         sq_valid_ff <= rd_pend_ff;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;

   `ASSERT_CLK(a_div_start_idle, clock, reset, div_req.start |-> !div_rsp.busy, "divider restarted while busy")
   `ASSERT_CLK(a_accept_divides, clock, reset, req_take |=> (state_ff == ST_DIVX), "accepted word did not start the cell division")
   `ASSERT_NEVER(a_write_in_range, clock, reset, mem_we && (j_ff >= n_ff), "feature write beyond the cell's feature count")
   `ASSERT_CLK(a_scan_cached, clock, reset, (state_ff == ST_SCAN) |-> cache_valid_ff, "scan without a valid cell cache")

endmodule

>>> tb/worley_noise_pixel_unit_tb.sv
// Self-checking testbench for the Worley F1 noise pixel unit.
module worley_noise_pixel_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wnp_pkg::*;

   // Features per cell and an index the block must ignore.
   localparam int                     CELL_FEATURES    = MAX_FEATURE_LIMIT_DEF - 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd5;

   // The idling modes, one per phase, in rotation.
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } pixel_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [COORD_W-1:0]     req_pixel_x;
   logic [COORD_W-1:0]     req_pixel_y;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [DIST_W-1:0]      rsp_distance;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   // The testbench's copy of the configuration registers.
   logic [31:0] seed_reg;
   logic [31:0] size_reg;
   logic [31:0] across_reg;
   logic [31:0] down_reg;

   pixel_type         pixel_queue[$];
   logic [DIST_W-1:0] distance_queue[$];
   int                failures;
   int                sender_idle_pct;
   int                receiver_stall_pct;
   pixel_type         last_pixel;

   worley_noise_pixel_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_distance     (rsp_distance),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Cell indices past the far edge wrap to zero and index -1 wraps to the last
   // cell, taken as a 32-bit value so that a count of zero gives all ones.
   function automatic logic [31:0] wrapped_cell(input longint idx, input logic [31:0] count);
      if (idx >= longint'(count)) begin
         return 32'd0;
      end
      if (idx < 0) begin
         return count - 32'd1;
      end
      return idx[31:0];
   endfunction

   function automatic logic [31:0] seed_step(input logic [31:0] s);
      return LCG_MUL * s + LCG_ADD;
   endfunction

   function automatic logic [31:0] hash_in(input logic [31:0] s, input logic [31:0] v);
      return ((FNV_BASIS ^ s) * FNV_PRIME) ^ v;
   endfunction

   // Exact floor square root, two bits of the radicand per step.
   function automatic longint unsigned isqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // Nearest-feature distance of one pixel under the current registers. The
   // cells are rebuilt every time; since a cell's features depend only on its
   // indices and the registers, the block's cache cannot change the answer.
   function automatic logic [DIST_W-1:0] nearest_distance(input pixel_type p);
      longint          cs;
      longint          ccol;
      longint          crow;
      longint          col;
      longint          row;
      longint          fcol;
      longint          frow;
      longint          ddx;
      longint          ddy;
      longint unsigned best;
      longint unsigned d;
      logic [31:0]     s;
      int              n;
      cs = (size_reg[15:0] == 0) ? 1 : longint'(size_reg[15:0]);
      ccol = longint'(p.x) / cs;
      crow = longint'(p.y) / cs;
      best = cs + (cs >> 1);
      for (int dy = 0; dy < 3; dy++) begin
         for (int dx = 0; dx < 3; dx++) begin
            col = ccol + dx - 1;
            row = crow + dy - 1;
            s = hash_in(seed_reg, wrapped_cell(col, across_reg));
            s = hash_in(s, wrapped_cell(row, down_reg));
            s = seed_step(s);
            n = int'(s % CELL_FEATURES) + 1;
            for (int j = 0; j < n; j++) begin
               s = seed_step(s);
               fcol = col * cs + longint'(s % cs[31:0]);
               s = seed_step(s);
               frow = row * cs + longint'(s % cs[31:0]);
               ddx = longint'(p.x) - fcol;
               ddy = longint'(p.y) - frow;
               d = isqrt(longint'(ddx * ddx) + longint'(ddy * ddy));
               if (d < best) best = d;
            end
         end
      end
      return best[DIST_W-1:0];
   endfunction

   // Driver. A word is taken at an edge with valid high and stall low; at that
   // edge its expected distance is queued, then the next word (or a gap) is set up.
   always @(posedge clock) begin
      pixel_type p;
      pixel_type taken;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            taken.x = req_pixel_x;
            taken.y = req_pixel_y;
            distance_queue.push_back(nearest_distance(taken));
         end
         if (!req_valid || !req_stall) begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               p = pixel_queue.pop_front();
               req_valid   <= 1'b1;
               req_pixel_x <= p.x;
               req_pixel_y <= p.y;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. Every response word is checked against the oldest expectation.
   always @(posedge clock) begin
      logic [DIST_W-1:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (distance_queue.size() == 0) begin
               $display("%0t: response word with no pixel pending, expected none, actual %0d",
                        $realtime, rsp_distance);
               failures++;
            end else begin
               want = distance_queue.pop_front();
               if (rsp_distance !== want) begin
                  $display("%0t: distance mismatch, expected %0d, actual %0d",
                           $realtime, want, rsp_distance);
                  failures++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   task automatic set_idle(input idle_mode_type mode);
      sender_idle_pct    = (mode == IDLE_SENDER) ? 57 : (mode == IDLE_BOTH) ? 31 : 0;
      receiver_stall_pct = (mode == IDLE_RECEIVER) ? 57 : (mode == IDLE_BOTH) ? 31 : 0;
   endtask

   // Waits until every queued word was sent and every distance came back.
   task automatic wait_drained();
      while (pixel_queue.size() != 0 || req_valid || distance_queue.size() != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   // Register write; only called with the block idle. The local copy follows
   // the same masking as the hardware register widths.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_BASE_SEED:    seed_reg = val;
         CSR_CELL_SIDE:    size_reg = {16'd0, val[15:0]};
         CSR_CELLS_ACROSS: across_reg = {15'd0, val[16:0]};
         CSR_CELLS_DOWN:   down_reg = {15'd0, val[16:0]};
         default: ;
      endcase
   endtask

   task automatic configure(input logic [31:0] seed, input logic [31:0] cs,
                            input logic [31:0] across, input logic [31:0] down);
      write_register(CSR_BASE_SEED, seed);
      write_register(CSR_CELL_SIDE, cs);
      write_register(CSR_CELLS_ACROSS, across);
      write_register(CSR_CELLS_DOWN, down);
   endtask

   task automatic queue_pixel(input logic [15:0] x, input logic [15:0] y);
      pixel_type p;
      p.x = x;
      p.y = y;
      pixel_queue.push_back(p);
      last_pixel = p;
   endtask

   // Most random pixels stay in the previous pixel's cell so that the cache is
   // reused; the rest jump anywhere, which usually forces a rebuild of nine cells.
   task automatic queue_random(input int count);
      int cs;
      int bx;
      int by;
      for (int i = 0; i < count; i++) begin
         cs = (size_reg[15:0] == 0) ? 1 : int'(size_reg[15:0]);
         if ($urandom_range(99) < 70) begin
            bx = (int'(last_pixel.x) / cs) * cs + $urandom_range(cs - 1);
            by = (int'(last_pixel.y) / cs) * cs + $urandom_range(cs - 1);
            queue_pixel((bx > 65535) ? 16'hFFFF : bx[15:0],
                        (by > 65535) ? 16'hFFFF : by[15:0]);
         end else begin
            queue_pixel(16'($urandom), 16'($urandom));
         end
      end
   endtask

   initial begin
      logic [31:0] cs;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_pixel_x      = '0;
      req_pixel_y      = '0;
      rsp_stall        = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_BASE_SEED;
      csr_write_data   = '0;
      failures         = 0;
      seed_reg         = 32'd0;
      size_reg         = 32'd256;
      across_reg       = 32'd1;
      down_reg         = 32'd1;
      last_pixel.x     = '0;
      last_pixel.y     = '0;
      set_idle(IDLE_NONE);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: corners, cell borders and the far edge of the space.
      queue_pixel(16'd0, 16'd0);
      queue_pixel(16'd255, 16'd0);
      queue_pixel(16'd256, 16'd256);
      queue_pixel(16'hFFFF, 16'hFFFF);
      queue_pixel(16'hFFFF, 16'd0);
      queue_pixel(16'd0, 16'hFFFF);
      wait_drained();

      // One-pixel cells and the widest wrap: every pixel is its own cell and the
      // far edge wraps back to column zero.
      configure(32'hFFFF_FFFF, 32'd1, 32'd65536, 32'd65536);
      queue_pixel(16'd0, 16'd0);
      queue_pixel(16'hFFFF, 16'hFFFF);
      queue_pixel(16'hFFFF, 16'hFFFF);
      queue_pixel(16'h5555, 16'hAAAA);
      wait_drained();

      // Largest cells with zero counts: the wrap of index -1 gives all ones.
      // The extra write with an unused index must change nothing.
      configure(32'd0, 32'd65535, 32'd0, 32'd0);
      write_register(CSR_UNUSED_INDEX, 32'hDEAD_BEEF);
      queue_pixel(16'd0, 16'd0);
      queue_pixel(16'hFFFF, 16'hFFFF);
      queue_pixel(16'hFFFE, 16'd1);
      wait_drained();

      // Zero cell size acts as one; counts are cut to the 17-bit register width.
      configure(32'h1234_5678, 32'd0, 32'h1FFFF, 32'hFFFF_FFFF);
      queue_pixel(16'd0, 16'd0);
      queue_pixel(16'd7, 16'hFFFF);
      queue_pixel(16'hFFFF, 16'd3);
      wait_drained();

      // Random phases: random settings, idling rotated through every mode.
      for (int ph = 0; ph < 12; ph++) begin
         set_idle(idle_mode_type'(ph % 4));
         case (ph % 4)
            0: cs = $urandom_range(2, 16);
            1: cs = $urandom_range(17, 300);
            2: cs = $urandom_range(301, 4096);
            default: cs = $urandom_range(4097, 65535);
         endcase
         configure($urandom, cs, $urandom_range(1, 65536 / cs + 2),
                   $urandom_range(1, 65536 / cs + 2));
         queue_random(36);
         wait_drained();
      end

      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/wnp_pkg.sv
hdl/wnp_divider.sv
hdl/worley_noise_pixel_unit.sv
tb/worley_noise_pixel_unit_tb.sv
